// File: sv/wlss_pkg.sv
// ----------------------------------------------------------------------------
// wlss_pkg
// Types, constants and time helpers for the wake light schedule selector.
// ----------------------------------------------------------------------------
package wlss_pkg;

	typedef logic [10:0] hm_t;     // hour in 10:6, minute in 5:0

	typedef struct packed {
		logic       cmd;
		logic [4:0] now_hour;
		logic [5:0] now_minute;
	} in_word_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] brightness;
		logic       nap_on;
	} out_word_t;

	typedef struct packed {
		logic flag;
		hm_t  begin_time;
		hm_t  wake_time;
		hm_t  end_time;
	} nap_state_t;

	typedef struct packed {
		logic [4:0]  wake_hour;
		logic [5:0]  wake_minute;
		logic [31:0] night_color;
		logic [31:0] wake_color;
	} cfg_t;

	typedef enum logic [1:0] {
		REG_WAKE_HOUR   = 2'd0,
		REG_WAKE_MINUTE = 2'd1,
		REG_NIGHT_COLOR = 2'd2,
		REG_WAKE_COLOR  = 2'd3
	} reg_idx_t;

	localparam logic        CMD_PRESS         = 1'b1;
	localparam logic [4:0]  WAKE_HOUR_RST     = 5'd7;
	localparam logic [5:0]  WAKE_MINUTE_RST   = 6'd0;
	localparam hm_t         NIGHT_START       = {5'd18, 6'd0};
	localparam logic [31:0] DEFAULT_NIGHT     = 32'h0105_000B;
	localparam logic [31:0] DEFAULT_WAKE      = 32'h0100_0C02;
	localparam logic [4:0]  WAKE_SPAN_H       = 5'd2;
	localparam logic [5:0]  WAKE_SPAN_M       = 6'd0;
	localparam logic [4:0]  NAP_WAKE_H        = 5'd2;
	localparam logic [5:0]  NAP_WAKE_M        = 6'd30;
	localparam logic [4:0]  NAP_END_H         = 5'd4;
	localparam logic [5:0]  NAP_END_M         = 6'd59;
	localparam logic [6:0]  MINUTES_PER_HOUR  = 7'd60;
	localparam logic [5:0]  HOURS_PER_DAY     = 6'd24;

	// Minute carry taken once, hour wrapped once (sum never reaches 48).
	function automatic hm_t add_hm(hm_t t, logic [4:0] h, logic [5:0] m);
		logic [6:0] mm;
		logic [5:0] hh;
		mm = {1'b0, t[5:0]} + {1'b0, m};
		hh = {1'b0, t[10:6]} + {1'b0, h};
		if (mm >= MINUTES_PER_HOUR) begin
			mm = mm - MINUTES_PER_HOUR;
			hh = hh + 6'd1;
		end
		if (hh >= HOURS_PER_DAY) begin
			hh = hh - HOURS_PER_DAY;
		end
		return {hh[4:0], mm[5:0]};
	endfunction

	// Inclusive window, wraps past midnight when s > e.
	function automatic logic in_window(hm_t s, hm_t c, hm_t e);
		logic r;
		if (c == s || c == e) begin
			r = 1'b1;
		end else if (s > e) begin
			r = !(c >= e && c <= s);
		end else begin
			r = (c >= s && c <= e);
		end
		return r;
	endfunction

endpackage

// File: sv/wlss_select.sv
// ----------------------------------------------------------------------------
// wlss_select
// Nap update and color choice for one word against the current nap state.
// ----------------------------------------------------------------------------
module wlss_select (
	input  wlss_pkg::in_word_t   word,
	input  wlss_pkg::cfg_t       cfg,
	input  wlss_pkg::nap_state_t nap,
	output wlss_pkg::nap_state_t nap_next,
	output wlss_pkg::out_word_t  result
);
	import wlss_pkg::*;

	hm_t         now;
	hm_t         wake_start;
	hm_t         wake_end;
	logic [31:0] night;
	logic [31:0] wake;
	logic [31:0] led;
	nap_state_t  nap_mid;

	assign now        = {word.now_hour, word.now_minute};
	assign wake_start = {cfg.wake_hour, cfg.wake_minute};
	assign wake_end   = add_hm(wake_start, WAKE_SPAN_H, WAKE_SPAN_M);
	assign night      = (cfg.night_color != '0) ? cfg.night_color : DEFAULT_NIGHT;
	assign wake       = (cfg.wake_color != '0) ? cfg.wake_color : DEFAULT_WAKE;

	always_comb begin
		nap_mid = nap;
		if (word.cmd == CMD_PRESS) begin
			if (nap.flag) begin
				nap_mid.flag = 1'b0;
			end else begin
				nap_mid.flag       = 1'b1;
				nap_mid.begin_time = now;
				nap_mid.wake_time  = add_hm(now, NAP_WAKE_H, NAP_WAKE_M);
				nap_mid.end_time   = add_hm(now, NAP_END_H, NAP_END_M);
			end
		end
	end

	always_comb begin
		if (nap_mid.flag && in_window(nap_mid.wake_time, now, nap_mid.end_time)) begin
			led = wake;
		end else if (nap_mid.flag &&
				in_window(nap_mid.begin_time, now, nap_mid.wake_time)) begin
			led = night;
		end else if (in_window(wake_start, now, wake_end)) begin
			led = wake;
		end else if (in_window(NIGHT_START, now, wake_start)) begin
			led = night;
		end else begin
			led = '0;
		end
	end

	always_comb begin
		nap_next = nap_mid;
		if (nap_mid.flag && !in_window(nap_mid.begin_time, now, nap_mid.end_time)) begin
			nap_next.flag = 1'b0;
		end
	end

	assign result.red        = led[7:0];
	assign result.green      = led[15:8];
	assign result.blue       = led[23:16];
	assign result.brightness = led[31:24];
	assign result.nap_on     = nap_next.flag;

endmodule

// File: sv/wake_light_schedule_selector_core.sv
// ----------------------------------------------------------------------------
// wake_light_schedule_selector_core
// Picks the LED color for each clock update or button press.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_word carries a command (update or press)
// and the current hour and minute. Output channel out_valid/out_stall/out_word
// returns one color word plus the nap flag for every input word.
// A word is held in the input register, is resolved there against the
// nap state and lands in the output register, which raises out_valid; one
// word per cycle is sustained while out_stall stays low.
// The output register and the input register each hold a word, so one word is
// still taken while a finished result waits; with both full, in_stall rises.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle, a
// user rule the block does not enforce. Reset clears nap state and both
// valid flags, and loads wake time 07:00 and zero colors (built-in defaults).
// ----------------------------------------------------------------------------
module wake_light_schedule_selector_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  wlss_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output wlss_pkg::out_word_t out_word,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import wlss_pkg::*;

	cfg_t       cfg_q;
	nap_state_t nap_q;
	nap_state_t nap_next;
	in_word_t   word_s1;
	logic       valid_s1;
	out_word_t  result;
	logic       adv;
	logic       in_acc;

	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wake_hour   <= WAKE_HOUR_RST;
			cfg_q.wake_minute <= WAKE_MINUTE_RST;
			cfg_q.night_color <= '0;
			cfg_q.wake_color  <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_WAKE_HOUR:   cfg_q.wake_hour   <= cfg_data[4:0];
				REG_WAKE_MINUTE: cfg_q.wake_minute <= cfg_data[5:0];
				REG_NIGHT_COLOR: cfg_q.night_color <= cfg_data;
				REG_WAKE_COLOR:  cfg_q.wake_color  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			word_s1 <= in_word;
		end
	end

	wlss_select u_select (
		.word     (word_s1),
		.cfg      (cfg_q),
		.nap      (nap_q),
		.nap_next (nap_next),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nap_q <= '0;
		end else if (adv) begin
			nap_q <= nap_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_word <= result;
		end
	end

	a_nap_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid && (out_word.nap_on == nap_q.flag))
		else $error("nap_on differs from nap state");

	a_press_starts_nap: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (word_s1.cmd == CMD_PRESS) && !nap_q.flag |=> out_word.nap_on)
		else $error("press did not start nap");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled with room available");

endmodule
